// ----- rtl/fwsk_pkg.sv -----
// Shared types, constants and the arctangent table for the steering kinematics block.
package fwsk_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0]  CFG_BASE_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0]  CFG_TRACK_WIDTH = 1'b1;
    localparam logic [CFG_DATA_W-1:0] CFG_RESET_VALUE = 24'd65536;

    localparam logic signed [31:0] HALF_PI_Q30 = 32'sd1686629713;
    localparam logic [50:0]        RATIO_ONE   = 51'd65536;
    localparam logic [1:0]         WHEEL_LAST  = 2'd3;

    typedef logic signed [33:0] t_coord;

    typedef struct packed {
        logic               req_type;
        logic signed [31:0] turn_radius;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] speed_command;
    } t_req;

    typedef struct packed {
        logic signed [15:0] steer_front_left;
        logic signed [15:0] steer_front_right;
        logic signed [15:0] steer_back_right;
        logic signed [15:0] steer_back_left;
        logic signed [31:0] drive_front_left;
        logic signed [31:0] drive_front_right;
        logic signed [31:0] drive_back_right;
        logic signed [31:0] drive_back_left;
    } t_rsp;

    // One classified command: per wheel an offset pair and two sign flags,
    // wheels ordered front left, front right, back right, back left.
    typedef struct packed {
        logic               req_type;
        logic signed [31:0] speed;
        t_coord             rad_x;
        t_coord             rad_y;
        logic [34:0]        den_abs;
        t_coord [3:0]       px;
        t_coord [3:0]       py;
        logic [3:0]         aneg;
        logic [3:0]         dneg;
    } t_job;

    typedef enum logic [3:0] {
        B_IDLE,
        B_LOAD,
        B_RAD_WAIT,
        B_WHEEL,
        B_WHEEL_WAIT,
        B_DIV,
        B_DIV_WAIT,
        B_DRV1,
        B_DRV2,
        B_DRV3,
        B_OUT
    } t_bstate;

    // atan(2^-i) in Q.30 radians
    function automatic logic [30:0] atan_q30(input logic [4:0] idx);
        case (idx)
            5'd0:    return 31'd843314857;
            5'd1:    return 31'd497837829;
            5'd2:    return 31'd263043837;
            5'd3:    return 31'd133525159;
            5'd4:    return 31'd67021687;
            5'd5:    return 31'd33543516;
            5'd6:    return 31'd16775851;
            5'd7:    return 31'd8388437;
            5'd8:    return 31'd4194283;
            5'd9:    return 31'd2097149;
            5'd10:   return 31'd1048576;
            5'd11:   return 31'd524288;
            5'd12:   return 31'd262144;
            5'd13:   return 31'd131072;
            5'd14:   return 31'd65536;
            5'd15:   return 31'd32768;
            5'd16:   return 31'd16384;
            5'd17:   return 31'd8192;
            5'd18:   return 31'd4096;
            5'd19:   return 31'd2048;
            5'd20:   return 31'd1024;
            5'd21:   return 31'd512;
            5'd22:   return 31'd256;
            5'd23:   return 31'd128;
            default: return 31'd0;
        endcase
    endfunction

endpackage

// ----- rtl/fwsk_fifo.sv -----
// Small register FIFO used for the command queue and the result queue.
module fwsk_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push & ~o_full;
    assign w_pop   = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CW'(w_push) - CW'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- rtl/fwsk_front.sv -----
// Front end: turns a steering command into per-wheel offsets and sign flags.
module fwsk_front (
    input  fwsk_pkg::t_req                    i_req,
    input  logic [fwsk_pkg::CFG_DATA_W-1:0]   i_base_len,
    input  logic [fwsk_pkg::CFG_DATA_W-1:0]   i_track_w,
    output fwsk_pkg::t_job                    o_job
);
    import fwsk_pkg::*;

    t_coord      w_hl, w_hw, w_r, w_dl, w_dr, w_cx, w_cy, w_fx, w_bx, w_ly, w_ry;
    logic [33:0] w_r_abs, w_cy_abs;
    logic        w_k, w_inv, w_flip;

    always_comb begin
        // half lengths in Q.17 are the raw register values
        w_hl     = {10'd0, i_base_len};
        w_hw     = {10'd0, i_track_w};
        w_r      = {i_req.turn_radius[31], i_req.turn_radius, 1'b0};
        w_cx     = {i_req.center_x[31], i_req.center_x, 1'b0};
        w_cy     = {i_req.center_y[31], i_req.center_y, 1'b0};
        w_dl     = w_r - w_hw;
        w_dr     = w_r + w_hw;
        w_fx     = w_cx - w_hl;
        w_bx     = w_cx + w_hl;
        w_ly     = w_cy - w_hw;
        w_ry     = w_cy + w_hw;
        w_r_abs  = w_r[33] ? 34'(-w_r) : 34'(w_r);
        w_cy_abs = w_cy[33] ? 34'(-w_cy) : 34'(w_cy);
        w_k      = (w_r_abs >= 34'(w_hw));
        w_inv    = (w_cy_abs > 34'(w_hw));
        // center of rotation on the left wheel line, behind the front axle
        w_flip   = (w_ly == '0) && w_fx[33];

        o_job.req_type = i_req.req_type;
        o_job.speed    = i_req.speed_command;
        o_job.rad_x    = w_cx;
        o_job.rad_y    = w_cy;
        o_job.den_abs  = {1'b0, w_r_abs};
        if (!i_req.req_type) begin
            o_job.px   = {w_hl, w_hl, w_hl, w_hl};
            o_job.py   = {w_dl, w_dr, w_dr, w_dl};
            o_job.aneg = 4'b1100;
            o_job.dneg = {1'b0, ~w_k, ~w_k, 1'b0};
        end else begin
            o_job.px   = {w_bx, w_bx, w_fx, w_fx};
            o_job.py   = {w_ly, w_ry, w_ry, w_ly};
            o_job.aneg = {~w_flip, 1'b1, 1'b1, ~w_flip};
            o_job.dneg = {~w_inv, 1'b0, 1'b0, ~w_inv};
        end
    end

endmodule

// ----- rtl/fwsk_root.sv -----
// Hypotenuse unit: two squares, then a restoring square root, two bits per cycle.
module fwsk_root (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  fwsk_pkg::t_coord i_a,
    input  fwsk_pkg::t_coord i_b,
    output logic             o_valid,
    output logic [34:0]      o_hyp
);
    import fwsk_pkg::*;

    localparam logic [5:0] LAST_STEP = 6'd33;

    logic [33:0] w_ua, w_ub, w_rem_n, w_trial;
    logic [1:0]  w_s;
    logic [30:0] w_sq_in;
    logic [61:0] w_sq;
    logic        w_ge;

    logic [30:0] r_ua, r_ub;
    logic [1:0]  r_s;
    logic [63:0] r_opd;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [5:0]  r_cnt;
    logic        r_busy, r_valid;

    always_comb begin
        w_ua    = i_a[33] ? 34'(-i_a) : 34'(i_a);
        w_ub    = i_b[33] ? 34'(-i_b) : 34'(i_b);
        w_s     = (w_ua[33] | w_ub[33]) ? 2'd3 :
                  (w_ua[32] | w_ub[32]) ? 2'd2 :
                  (w_ua[31] | w_ub[31]) ? 2'd1 : 2'd0;
        w_sq_in = (r_cnt == 6'd0) ? r_ua : r_ub;
        w_sq    = 62'(w_sq_in) * 62'(w_sq_in);
        w_rem_n = {r_rem[31:0], r_opd[63:62]};
        w_trial = {r_root, 2'b01};
        w_ge    = (w_rem_n >= w_trial);
    end

    assign o_valid = r_valid;
    assign o_hyp   = {3'd0, r_root} << r_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_valid <= 1'b0;
            r_cnt   <= '0;
            r_ua    <= 31'(w_ua >> w_s);
            r_ub    <= 31'(w_ub >> w_s);
            r_s     <= w_s;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == 6'd0) begin
                r_opd <= {2'd0, w_sq};
            end else if (r_cnt == 6'd1) begin
                r_opd  <= r_opd + {2'd0, w_sq};
                r_rem  <= '0;
                r_root <= '0;
            end else begin
                r_opd  <= {r_opd[61:0], 2'b00};
                r_rem  <= w_ge ? w_rem_n - w_trial : w_rem_n;
                r_root <= {r_root[30:0], w_ge};
                if (r_cnt == LAST_STEP) begin
                    r_busy  <= 1'b0;
                    r_valid <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- rtl/fwsk_div.sv -----
// Ratio unit: restoring divide of hyp * 2^16 by the turn radius, one bit per cycle.
module fwsk_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [34:0] i_num,
    input  logic [34:0] i_den,
    output logic        o_valid,
    output logic [50:0] o_quo
);
    import fwsk_pkg::*;

    localparam logic [5:0] LAST_BIT = 6'd50;

    logic [50:0] r_num, r_quo;
    logic [35:0] r_rem, w_rem_n;
    logic [34:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy, r_valid, w_ge;

    assign w_rem_n = {r_rem[34:0], r_num[50]};
    assign w_ge    = (w_rem_n >= {1'b0, r_den});
    assign o_valid = r_valid;
    assign o_quo   = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else if (i_start) begin
            r_cnt <= '0;
            if (i_den == '0) begin
                // zero radius: every ratio is exactly one
                r_quo   <= RATIO_ONE;
                r_busy  <= 1'b0;
                r_valid <= 1'b1;
            end else begin
                r_num   <= {i_num, 16'd0};
                r_den   <= i_den;
                r_rem   <= '0;
                r_busy  <= 1'b1;
                r_valid <= 1'b0;
            end
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_num <= {r_num[49:0], 1'b0};
            r_rem <= w_ge ? w_rem_n - {1'b0, r_den} : w_rem_n;
            r_quo <= {r_quo[49:0], w_ge};
            if (r_cnt == LAST_BIT) begin
                r_busy  <= 1'b0;
                r_valid <= 1'b1;
            end
        end
    end

endmodule

// ----- rtl/fwsk_cordic.sv -----
// Arctangent unit: normalize, then one vectoring CORDIC stage per cycle.
module fwsk_cordic #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  fwsk_pkg::t_coord   i_num,
    input  fwsk_pkg::t_coord   i_den,
    output logic               o_valid,
    output logic signed [31:0] o_z
);
    import fwsk_pkg::*;

    localparam int SW = $clog2(CORDIC_STAGES);

    logic signed [43:0] r_x, r_y, w_xs, w_ys;
    logic signed [31:0] r_z, w_step;
    logic [40:0]        w_or;
    logic [SW-1:0]      r_i;
    logic               r_neg, r_norm, r_busy, r_valid;

    always_comb begin
        w_or   = r_x[40:0] | r_y[40:0];
        w_xs   = r_x >>> r_i;
        w_ys   = r_y >>> r_i;
        w_step = {1'b0, atan_q30(5'(r_i))};
    end

    assign o_valid = r_valid;
    assign o_z     = r_neg ? -r_z : r_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_norm  <= 1'b0;
            r_i     <= '0;
        end else if (i_start) begin
            r_i <= '0;
            if (i_den == '0) begin
                r_neg   <= 1'b0;
                r_z     <= i_num[33] ? -HALF_PI_Q30 : ((i_num == '0) ? '0 : HALF_PI_Q30);
                r_busy  <= 1'b0;
                r_valid <= 1'b1;
            end else if (i_num == '0) begin
                r_neg   <= 1'b0;
                r_z     <= '0;
                r_busy  <= 1'b0;
                r_valid <= 1'b1;
            end else begin
                r_neg   <= i_num[33] ^ i_den[33];
                r_x     <= 44'(i_den[33] ? 34'(-i_den) : 34'(i_den));
                r_y     <= 44'(i_num[33] ? 34'(-i_num) : 34'(i_num));
                r_z     <= '0;
                r_norm  <= 1'b1;
                r_busy  <= 1'b1;
                r_valid <= 1'b0;
            end
        end else if (r_busy && r_norm) begin
            // bring the larger magnitude up to bit 40
            if (w_or[40]) begin
                r_norm <= 1'b0;
            end else if (w_or[40:33] == '0) begin
                r_x <= r_x <<< 8;
                r_y <= r_y <<< 8;
            end else begin
                r_x <= r_x <<< 1;
                r_y <= r_y <<< 1;
            end
        end else if (r_busy) begin
            if (!r_y[43]) begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_step;
            end else begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_step;
            end
            if (r_i == SW'(CORDIC_STAGES - 1)) begin
                r_busy  <= 1'b0;
                r_valid <= 1'b1;
            end else begin
                r_i <= r_i + 1'b1;
            end
        end
    end

endmodule

// ----- rtl/fwsk_back.sv -----
// Back end: sequences the shared root, arctangent, divide and multiply per wheel.
module fwsk_back #(
    parameter int ANGLE_FRAC_BITS = 13,
    parameter int CORDIC_STAGES   = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fwsk_pkg::t_job i_job,
    input  logic           i_job_empty,
    output logic           o_job_pop,
    output fwsk_pkg::t_rsp o_rsp,
    output logic           o_rsp_push,
    input  logic           i_rsp_full
);
    import fwsk_pkg::*;

    localparam int RND_BIT = 29 - ANGLE_FRAC_BITS;
    localparam int RND_SH  = 30 - ANGLE_FRAC_BITS;

    t_bstate            r_state, n_state;
    t_job               r_job;
    logic [1:0]         r_wheel;
    logic [34:0]        r_den;
    logic signed [15:0] r_ang [4];
    logic signed [31:0] r_drv [4];
    logic [63:0]        r_p1;
    logic [50:0]        r_p2;

    logic               w_root_start, w_root_valid, w_cor_start, w_cor_valid;
    logic               w_div_start, w_div_valid;
    t_coord             w_root_a, w_root_b;
    logic [34:0]        w_hyp;
    logic signed [31:0] w_z, w_zf;
    logic [50:0]        w_ratio;

    logic [31:0]        w_zmag, w_q, w_m, w_mul_b;
    logic signed [15:0] w_ang;
    logic [63:0]        w_prod;
    logic [64:0]        w_sum;
    logic [30:0]        w_p;
    logic               w_sat, w_neg;
    logic signed [31:0] w_drv;

    fwsk_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_root_start),
        .i_a     (w_root_a),
        .i_b     (w_root_b),
        .o_valid (w_root_valid),
        .o_hyp   (w_hyp)
    );

    fwsk_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cor_start),
        .i_num   (r_job.px[r_wheel]),
        .i_den   (r_job.py[r_wheel]),
        .o_valid (w_cor_valid),
        .o_z     (w_z)
    );

    fwsk_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_hyp),
        .i_den   (r_den),
        .o_valid (w_div_valid),
        .o_quo   (w_ratio)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:       if (!i_job_empty) n_state = B_LOAD;
            B_LOAD:       n_state = r_job.req_type ? B_RAD_WAIT : B_WHEEL;
            B_RAD_WAIT:   if (w_root_valid) n_state = B_WHEEL;
            B_WHEEL:      n_state = B_WHEEL_WAIT;
            B_WHEEL_WAIT: if (w_root_valid && w_cor_valid) n_state = B_DIV;
            B_DIV:        n_state = B_DIV_WAIT;
            B_DIV_WAIT:   if (w_div_valid) n_state = B_DRV1;
            B_DRV1:       n_state = B_DRV2;
            B_DRV2:       n_state = B_DRV3;
            B_DRV3:       n_state = (r_wheel == WHEEL_LAST) ? B_OUT : B_WHEEL;
            B_OUT:        if (!i_rsp_full) n_state = B_IDLE;
            default:      n_state = B_IDLE;
        endcase
    end

    // unit controls and handshakes
    always_comb begin
        o_job_pop    = (r_state == B_IDLE) && !i_job_empty;
        w_root_start = ((r_state == B_LOAD) && r_job.req_type) || (r_state == B_WHEEL);
        w_cor_start  = (r_state == B_WHEEL);
        w_div_start  = (r_state == B_DIV);
        o_rsp_push   = (r_state == B_OUT) && !i_rsp_full;
        w_root_a     = (r_state == B_WHEEL) ? r_job.px[r_wheel] : r_job.rad_x;
        w_root_b     = (r_state == B_WHEEL) ? r_job.py[r_wheel] : r_job.rad_y;
    end

    // angle rounding, half away from zero
    always_comb begin
        w_zf   = r_job.aneg[r_wheel] ? -w_z : w_z;
        w_zmag = w_zf[31] ? 32'(-w_zf) : 32'(w_zf);
        w_q    = (w_zmag + (32'd1 << RND_BIT)) >> RND_SH;
        w_ang  = w_zf[31] ? 16'(-w_q) : 16'(w_q);
    end

    // speed: ratio times |v| from its low 32 and high 19 bits, then saturate
    always_comb begin
        w_m     = r_job.speed[31] ? 32'(-r_job.speed) : 32'(r_job.speed);
        w_mul_b = (r_state == B_DRV1) ? w_ratio[31:0] : {13'd0, w_ratio[50:32]};
        w_prod  = w_m * w_mul_b;
        w_sum   = {18'd0, r_p2[14:0], 32'd0} + {1'b0, r_p1};
        w_sat   = (r_p2[50:15] != '0) || (w_sum[64:47] != '0);
        w_p     = w_sum[46:16];
        w_neg   = r_job.speed[31] ^ r_job.dneg[r_wheel];
        if (w_sat) begin
            w_drv = w_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            w_drv = w_neg ? -{1'b0, w_p} : {1'b0, w_p};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_wheel <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                B_IDLE: begin
                    if (!i_job_empty) r_job <= i_job;
                end
                B_LOAD: begin
                    r_wheel <= '0;
                    if (!r_job.req_type) r_den <= r_job.den_abs;
                end
                B_RAD_WAIT: begin
                    if (w_root_valid) r_den <= w_hyp;
                end
                B_DIV: begin
                    r_ang[r_wheel] <= w_ang;
                end
                B_DRV1: begin
                    r_p1 <= w_prod;
                end
                B_DRV2: begin
                    r_p2 <= w_prod[50:0];
                end
                B_DRV3: begin
                    r_drv[r_wheel] <= w_drv;
                    r_wheel        <= r_wheel + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_rsp.steer_front_left  = r_ang[0];
        o_rsp.steer_front_right = r_ang[1];
        o_rsp.steer_back_right  = r_ang[2];
        o_rsp.steer_back_left   = r_ang[3];
        o_rsp.drive_front_left  = r_drv[0];
        o_rsp.drive_front_right = r_drv[1];
        o_rsp.drive_back_right  = r_drv[2];
        o_rsp.drive_back_left   = r_drv[3];
    end

endmodule

// ----- rtl/four_wheel_steer_kinematics_unit.sv -----
// Four-wheel steering inverse kinematics: top level.
//
// Commands enter through a queue port: drive push with a command on i_req while full
// is low. Results leave through a queue port: while empty is low, o_rsp holds the oldest
// result, and pop takes it. Each command gives exactly one result, in order.
// Geometry registers (wheel base, track) are written through i_cfg_we/i_cfg_idx/
// i_cfg_data; the user must write them only while the block is idle, and the block
// itself does not enforce this. Both reset to 1.0 m. A two-entry command queue sits
// between the front end and the back end, and a two-entry result queue follows it,
// so commands keep coming in while results wait. The back end handles one command
// at a time, wheel by wheel: per wheel a start state, the hypotenuse (two squares plus
// a 32-step root, arctangent beside it), a start state, the divide and the multiply
// states B_DRV1, B_DRV2 and B_DRV3. A center-of-rotation command first takes one more
// hypotenuse than a radius command; a zero divisor cuts each divide short. The back
// end pops a new command only after the result of the last one is pushed. Reset is
// synchronous: it empties both queues, stops the back end and restores the geometry
// registers. When the receiver stalls, finished results pile up in the result queue,
// then the back end holds, and full rises once the command queue fills.
module four_wheel_steer_kinematics_unit #(
    parameter int ANGLE_FRAC_BITS = 13,
    parameter int CORDIC_STAGES   = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  fwsk_pkg::t_req                  i_req,
    output logic                            empty,
    input  logic                            pop,
    output fwsk_pkg::t_rsp                  o_rsp,
    input  logic                            i_cfg_we,
    input  logic [fwsk_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fwsk_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fwsk_pkg::*;

    localparam int JOB_W = $bits(t_job);
    localparam int RSP_W = $bits(t_rsp);

    logic [CFG_DATA_W-1:0] r_base_len, r_track_w;
    t_job                  w_job_in, w_job_out;
    t_rsp                  w_rsp;
    logic                  w_job_empty, w_job_pop, w_rsp_push, w_rsp_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_len <= CFG_RESET_VALUE;
            r_track_w  <= CFG_RESET_VALUE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BASE_LENGTH: r_base_len <= i_cfg_data;
                CFG_TRACK_WIDTH: r_track_w  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    fwsk_front u_front (
        .i_req      (i_req),
        .i_base_len (r_base_len),
        .i_track_w  (r_track_w),
        .o_job      (w_job_in)
    );

    fwsk_fifo #(.WIDTH(JOB_W), .DEPTH(2)) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_job_in),
        .o_full  (full),
        .i_pop   (w_job_pop),
        .o_data  (w_job_out),
        .o_empty (w_job_empty)
    );

    fwsk_back #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STAGES   (CORDIC_STAGES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_job_out),
        .i_job_empty (w_job_empty),
        .o_job_pop   (w_job_pop),
        .o_rsp       (w_rsp),
        .o_rsp_push  (w_rsp_push),
        .i_rsp_full  (w_rsp_full)
    );

    fwsk_fifo #(.WIDTH(RSP_W), .DEPTH(2)) u_rsp_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_rsp_push),
        .i_data  (w_rsp),
        .o_full  (w_rsp_full),
        .i_pop   (pop),
        .o_data  (o_rsp),
        .o_empty (empty)
    );

endmodule

// ----- rtl/fwsk_checker.sv -----
// Port-level checks for the steering kinematics block, bound to the top level.
module fwsk_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic push,
    input logic full,
    input logic pop,
    input logic empty
);
    logic [3:0] r_outstanding;

    // count items accepted and not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            r_outstanding <= r_outstanding + 4'(push && !full) - 4'(pop && !empty);
        end
    end

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not cleared by reset");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> r_outstanding != 4'd0)
        else $error("result shown with no item outstanding");

    a_full_backed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> r_outstanding >= 4'd2)
        else $error("full raised with fewer than two items outstanding");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting result dropped");

endmodule

bind four_wheel_steer_kinematics_unit fwsk_checker u_fwsk_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .push    (push),
    .full    (full),
    .pop     (pop),
    .empty   (empty)
);
